>>> rtl/whcp_pkg.sv
// Shared types and constants for the WAV header chunk parser.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package whcp_pkg;

	// Result status codes
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_BAD_FMT   = 3'd1;
	localparam logic [2:0] STAT_NOT_PCM   = 3'd2;
	localparam logic [2:0] STAT_BAD_WIDTH = 3'd3;
	localparam logic [2:0] STAT_MISSING   = 3'd4;

	// Four-character tags as little-endian words
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] MIN_FILE_SIZE = 32'd12;
	localparam logic [31:0] FMT_BODY_LEN  = 32'd16;
	localparam logic [32:0] RIFF_HDR_LEN  = 33'd8;
	localparam logic [15:0] PCM_CODE      = 16'd1;
	localparam logic [15:0] BPS_8         = 16'd8;
	localparam logic [15:0] BPS_16        = 16'd16;

	// One input item: a file byte with its context
	typedef struct packed {
		logic [7:0]  byte_value;
		logic [31:0] file_size;
		logic        file_start;
	} in_item_t;

	// One parse record from the front end, before the frame count
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic        sample_is_16bit;
		logic [31:0] data_offset;
		logic [31:0] data_bytes;
	} hdr_rec_t;

	// One result item
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic        sample_is_16bit;
		logic [31:0] data_offset;
		logic [31:0] data_bytes;
		logic [31:0] frame_count;
	} result_t;

endpackage

>>> rtl/wav_header_chunk_parser.sv
// WAV header chunk parser, top level. Takes one file byte per cycle while full is
// low; a file's result leaves the front end with its last parsed byte. The back end
// loads a good record, runs the one-bit-per-cycle divider and fills the output
// register (an error record skips the divider); it takes no new record until the
// last one is done. Full rises only while QUEUE_DEPTH results wait for the back end.
// Reset (arst_n low, asynchronous) clears all control state; parser starts at byte 0.
`timescale 1ns / 1ps

module wav_header_chunk_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  whcp_pkg::in_item_t  req,
	output logic                empty,
	input  logic                pop,
	output whcp_pkg::result_t   rsp
);

	logic               accept;
	logic               emit;
	whcp_pkg::hdr_rec_t front_rec;
	logic               q_valid;
	whcp_pkg::hdr_rec_t q_rec;
	logic               q_take;

	assign accept = push && !full;

	// front end: byte walker
	whcp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (req),
		.emit   (emit),
		.rec    (front_rec)
	);

	// decoupling queue
	whcp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (emit),
		.wr_data  (front_rec),
		.full     (full),
		.rd_valid (q_valid),
		.rd_data  (q_rec),
		.rd_en    (q_take)
	);

	// back end: frame count divider and output register
	whcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_valid),
		.rec       (q_rec),
		.rec_take  (q_take),
		.empty     (empty),
		.rsp       (rsp),
		.pop       (pop)
	);

`ifndef SYNTHESIS
	// a good result always has a nonzero channel count
	a_ok_has_channels: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == whcp_pkg::STAT_OK) |-> (rsp.channel_count != 16'd0))
		else $error("ok result with zero channels");

	// an error result carries no parameters
	a_err_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status != whcp_pkg::STAT_OK) |->
		(rsp.channel_count == 16'd0 && rsp.sample_rate == 32'd0 &&
		 rsp.data_bytes == 32'd0 && rsp.frame_count == 32'd0))
		else $error("error result with nonzero fields");

	// status codes stay in the defined range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rsp.status <= whcp_pkg::STAT_MISSING))
		else $error("status code out of range");
`endif

endmodule

>>> rtl/whcp_front.sv
// Byte-serial RIFF/WAVE chunk walker: checks tags and bounds, latches fmt and data info.
// Emits one parse record per file. Depends on whcp_pkg.
`timescale 1ns / 1ps

module whcp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  whcp_pkg::in_item_t  item,
	output logic                emit,
	output whcp_pkg::hdr_rec_t  rec
);

	typedef enum logic [4:0] {
		PH_HDR  = 5'b00001,
		PH_CHDR = 5'b00010,
		PH_FMT  = 5'b00100,
		PH_SKIP = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	// control state
	phase_t      phase_q;
	logic [3:0]  idx_q;
	logic [32:0] cur_q;
	logic [1:0]  found_q;
	// payload state
	logic [31:0] asm_q;
	logic [32:0] riff_end_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [31:0] skip_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic        wide_q;
	logic [31:0] dstart_q;
	logic [31:0] dlen_q;
	logic [15:0] pcode_q;
	logic [15:0] pchan_q;
	logic [31:0] prate_q;

	phase_t      nx_phase;
	logic [3:0]  nx_idx;
	logic [32:0] nx_cur;
	logic [1:0]  nx_found;
	logic [31:0] nx_asm;
	logic [32:0] nx_riff_end;
	logic [31:0] nx_tag;
	logic [31:0] nx_len;
	logic [31:0] nx_skip;
	logic [15:0] nx_chan;
	logic [31:0] nx_rate;
	logic        nx_wide;
	logic [31:0] nx_dstart;
	logic [31:0] nx_dlen;
	logic [15:0] nx_pcode;
	logic [15:0] nx_pchan;
	logic [31:0] nx_prate;

	phase_t      ph_e;
	logic [3:0]  idx_e;
	logic [32:0] cur_e;
	logic [32:0] cur_n;
	logic [31:0] asm_n;
	logic [33:0] chunk_reach;
	logic [31:0] skip_dec;
	logic [15:0] bps;
	logic        chunk_end;

	// a new file restarts the walk
	assign ph_e  = item.file_start ? PH_HDR : phase_q;
	assign idx_e = item.file_start ? 4'd0 : idx_q;
	assign cur_e = item.file_start ? 33'd0 : cur_q;
	assign cur_n = cur_e + 33'd1;
	assign asm_n = {item.byte_value, asm_q[31:8]};
	// chunk end minus one: length + offset before this byte
	assign chunk_reach = {2'b00, asm_n} + {1'b0, cur_e};
	assign skip_dec = (skip_q != 32'd0) ? (skip_q - 32'd1) : 32'd0;
	assign bps = asm_n[31:16];

	// next-state and record logic for one byte
	always_comb begin
		nx_phase    = phase_q;
		nx_idx      = idx_q;
		nx_cur      = cur_q;
		nx_found    = found_q;
		nx_asm      = asm_q;
		nx_riff_end = riff_end_q;
		nx_tag      = tag_q;
		nx_len      = len_q;
		nx_skip     = skip_q;
		nx_chan     = chan_q;
		nx_rate     = rate_q;
		nx_wide     = wide_q;
		nx_dstart   = dstart_q;
		nx_dlen     = dlen_q;
		nx_pcode    = pcode_q;
		nx_pchan    = pchan_q;
		nx_prate    = prate_q;
		emit        = 1'b0;
		rec         = '0;
		chunk_end   = 1'b0;

		if (accept) begin
			nx_phase = ph_e;
			nx_idx   = idx_e;
			nx_cur   = cur_e;
			nx_found = item.file_start ? 2'b00 : found_q;
		end

		if (accept && ph_e != PH_DONE) begin
			nx_asm = asm_n;
			nx_cur = cur_n;
			nx_idx = idx_e + 4'd1;
			case (ph_e)
				PH_HDR: begin
					if (idx_e == 4'd3) nx_tag = asm_n;
					if (idx_e == 4'd7) nx_riff_end = {1'b0, asm_n} + whcp_pkg::RIFF_HDR_LEN;
					if (idx_e == 4'd0 && item.file_size < whcp_pkg::MIN_FILE_SIZE) begin
						emit = 1'b1;
						rec.status = whcp_pkg::STAT_BAD_FMT;
						nx_phase = PH_DONE;
					end else if (idx_e == 4'd11) begin
						if (tag_q != whcp_pkg::TAG_RIFF || asm_n != whcp_pkg::TAG_WAVE ||
						    riff_end_q > {1'b0, item.file_size}) begin
							emit = 1'b1;
							rec.status = whcp_pkg::STAT_BAD_FMT;
							nx_phase = PH_DONE;
						end else begin
							chunk_end = 1'b1;
						end
					end
				end
				PH_CHDR: begin
					if (idx_e == 4'd3) nx_tag = asm_n;
					if (idx_e == 4'd7) begin
						nx_len = asm_n;
						nx_idx = idx_e;
						if (chunk_reach >= {1'b0, riff_end_q}) begin
							emit = 1'b1;
							rec.status = whcp_pkg::STAT_BAD_FMT;
							nx_phase = PH_DONE;
						end else if (tag_q == whcp_pkg::TAG_FMT) begin
							if (asm_n < whcp_pkg::FMT_BODY_LEN) begin
								emit = 1'b1;
								rec.status = whcp_pkg::STAT_BAD_FMT;
								nx_phase = PH_DONE;
							end else begin
								nx_phase = PH_FMT;
								nx_idx = 4'd0;
							end
						end else begin
							if (tag_q == whcp_pkg::TAG_DATA) begin
								nx_dstart = cur_n[31:0];
								nx_dlen = asm_n;
								nx_found = nx_found | 2'b10;
							end
							nx_skip = asm_n;
							if (asm_n == 32'd0) begin
								chunk_end = 1'b1;
							end else begin
								nx_phase = PH_SKIP;
							end
						end
					end
				end
				PH_FMT: begin
					if (idx_e == 4'd1) nx_pcode = asm_n[31:16];
					if (idx_e == 4'd3) nx_pchan = asm_n[31:16];
					if (idx_e == 4'd7) nx_prate = asm_n;
					if (idx_e == 4'd15) begin
						if (pcode_q != whcp_pkg::PCM_CODE) begin
							emit = 1'b1;
							rec.status = whcp_pkg::STAT_NOT_PCM;
							nx_phase = PH_DONE;
						end else if (bps != whcp_pkg::BPS_8 && bps != whcp_pkg::BPS_16) begin
							emit = 1'b1;
							rec.status = whcp_pkg::STAT_BAD_WIDTH;
							nx_phase = PH_DONE;
						end else begin
							nx_chan = pchan_q;
							nx_rate = prate_q;
							nx_wide = (bps == whcp_pkg::BPS_16);
							nx_found = nx_found | 2'b01;
							nx_skip = len_q - whcp_pkg::FMT_BODY_LEN;
							if (len_q == whcp_pkg::FMT_BODY_LEN) begin
								chunk_end = 1'b1;
							end else begin
								nx_phase = PH_SKIP;
							end
						end
					end
				end
				PH_SKIP: begin
					nx_idx = idx_e;
					nx_skip = skip_dec;
					if (skip_dec == 32'd0) chunk_end = 1'b1;
				end
				default: begin
					nx_phase = PH_DONE;
				end
			endcase

			// end of a chunk: either the extent is used up or the next header follows
			if (chunk_end) begin
				if (cur_n >= nx_riff_end) begin
					emit = 1'b1;
					nx_phase = PH_DONE;
					if (nx_found != 2'b11 || nx_chan == 16'd0) begin
						rec.status = whcp_pkg::STAT_MISSING;
					end else begin
						rec.status          = whcp_pkg::STAT_OK;
						rec.channel_count   = nx_chan;
						rec.sample_rate     = nx_rate;
						rec.sample_is_16bit = nx_wide;
						rec.data_offset     = nx_dstart;
						rec.data_bytes      = nx_dlen;
					end
				end else begin
					nx_phase = PH_CHDR;
					nx_idx = 4'd0;
				end
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			idx_q   <= 4'd0;
			cur_q   <= 33'd0;
			found_q <= 2'b00;
		end else begin
			phase_q <= nx_phase;
			idx_q   <= nx_idx;
			cur_q   <= nx_cur;
			found_q <= nx_found;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		asm_q      <= nx_asm;
		riff_end_q <= nx_riff_end;
		tag_q      <= nx_tag;
		len_q      <= nx_len;
		skip_q     <= nx_skip;
		chan_q     <= nx_chan;
		rate_q     <= nx_rate;
		wide_q     <= nx_wide;
		dstart_q   <= nx_dstart;
		dlen_q     <= nx_dlen;
		pcode_q    <= nx_pcode;
		pchan_q    <= nx_pchan;
		prate_q    <= nx_prate;
	end

endmodule

>>> rtl/whcp_queue.sv
// Small FIFO of parse records between the front end and the divider back end.
// Depends on whcp_pkg.
`timescale 1ns / 1ps

module whcp_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  whcp_pkg::hdr_rec_t  wr_data,
	output logic                full,
	output logic                rd_valid,
	output whcp_pkg::hdr_rec_t  rd_data,
	input  logic                rd_en
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	whcp_pkg::hdr_rec_t slot_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PW'(1);
			if (do_rd) rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wptr_q] <= wr_data;
	end

endmodule

>>> rtl/whcp_back.sv
// Back end: for a good record divides data bytes by bytes per frame one quotient bit a cycle,
// then holds the finished result item. Depends on whcp_pkg.
`timescale 1ns / 1ps

module whcp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	input  whcp_pkg::hdr_rec_t  rec,
	output logic                rec_take,
	output logic                empty,
	output whcp_pkg::result_t   rsp,
	input  logic                pop
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_DONE = 3'b100
	} bstate_t;

	bstate_t            state_q;
	logic [4:0]         cnt_q;
	logic               out_valid_q;
	whcp_pkg::hdr_rec_t hold_q;
	logic [31:0]        quo_q;
	logic [16:0]        rem_q;
	logic [16:0]        dvs_q;
	whcp_pkg::result_t  out_q;

	logic [17:0] rem_sh;
	logic        fits;
	logic        out_free;

	assign rem_sh   = {rem_q, quo_q[31]};
	assign fits     = (rem_sh >= {1'b0, dvs_q});
	assign out_free = !out_valid_q || pop;
	assign rec_take = (state_q == B_IDLE) && rec_valid;
	assign empty    = !out_valid_q;
	assign rsp      = out_q;

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the popped one in the same cycle
			if (state_q == B_DONE && out_free) out_valid_q <= 1'b1;
			else if (pop && out_valid_q) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					cnt_q <= 5'd0;
					if (rec_valid) begin
						state_q <= (rec.status == whcp_pkg::STAT_OK) ? B_DIV : B_DONE;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_free) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// restoring divider datapath and result register
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				hold_q <= rec;
				rem_q  <= 17'd0;
				quo_q  <= (rec.status == whcp_pkg::STAT_OK) ? rec.data_bytes : 32'd0;
				dvs_q  <= rec.sample_is_16bit ? {rec.channel_count, 1'b0}
				                              : {1'b0, rec.channel_count};
			end
			B_DIV: begin
				rem_q <= fits ? 17'(rem_sh - {1'b0, dvs_q}) : rem_sh[16:0];
				quo_q <= {quo_q[30:0], fits};
			end
			B_DONE: begin
				if (out_free) begin
					out_q.status          <= hold_q.status;
					out_q.channel_count   <= hold_q.channel_count;
					out_q.sample_rate     <= hold_q.sample_rate;
					out_q.sample_is_16bit <= hold_q.sample_is_16bit;
					out_q.data_offset     <= hold_q.data_offset;
					out_q.data_bytes      <= hold_q.data_bytes;
					out_q.frame_count     <= quo_q;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule
